FILE: src/rastrigin_fitness_accumulator_defines.svh
// Assertion macros shared by the rastrigin fitness accumulator modules.
`ifndef RASTRIGIN_FITNESS_ACCUMULATOR_DEFINES_SVH
`define RASTRIGIN_FITNESS_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define RFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rfa assertion failed");

// Next-cycle implication, gated off during reset.
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfa assertion failed");

`endif

FILE: src/rfa_pkg.sv
// Types, constants and the quarter-wave cosine table of the rastrigin accumulator.
package rfa_pkg;

	localparam int COS_DEPTH = 256;
	localparam int COS_W     = 12;
	localparam int TERM_W    = 21;
	localparam int SUM_W     = 31;
	localparam int FIT_W     = 31;
	localparam int ECNT_W    = 11;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	// (2n-1)*(2n) for the twelve Taylor terms
	localparam longint unsigned SERIES_DIV [12] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
	};

	typedef struct packed {
		logic [TERM_W-1:0] term;
		logic              last;
	} rfa_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rfa_q_status_t;

	// Entry k = round(2048*cos(pi/2*k/COS_DEPTH)), Q.11, via a fixed-point series.
	function automatic logic [COS_DEPTH*COS_W-1:0] build_cos_table();
		logic [COS_DEPTH*COS_W-1:0] tbl;
		longint unsigned theta;
		longint unsigned t2;
		longint unsigned term;
		longint unsigned v;
		longint acc;
		tbl = '0;
		for (int k = 0; k < COS_DEPTH; k++) begin
			theta = (HALF_PI_Q30 * longint'(k)) / COS_DEPTH;
			t2 = (theta * theta) >> 30;
			term = 64'd1 << 30;
			acc = 64'sd1 << 30;
			for (int n = 0; n < 12; n++) begin
				term = (term * t2) >> 30;
				term = term / SERIES_DIV[n];
				if ((n % 2) == 0) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (longint'(acc) * 64'd2048 + (64'd1 << 29)) >> 30;
			if (v > 64'd4095) begin
				v = 64'd4095;
			end
			tbl[k*COS_W +: COS_W] = v[COS_W-1:0];
		end
		return tbl;
	endfunction

	localparam logic [COS_DEPTH*COS_W-1:0] COS_ROM = build_cos_table();

endpackage

FILE: src/rastrigin_fitness_accumulator.sv
// Top level of the rastrigin fitness accumulator: front end, term queue, back end.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   input    | in_valid / in_ready | coordinate (Q5.10), last_coordinate
//   output   | out_valid/out_ready | fitness (Q.10, saturating), element_count
//
// Sustains one coordinate per cycle while the queue has room; each term is
// computed in the cycle it is accepted, and the back end folds one queued term
// per cycle unless a last entry waits on a stalled result. The last coordinate
// is queued, then loads the result register behind out_valid. The four-entry
// queue keeps input flowing until it fills. Reset clears sum, count and queue.
module rastrigin_fitness_accumulator #(
	parameter int MAX_VECTOR_LENGTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          coordinate,
	input  logic                        last_coordinate,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rfa_pkg::FIT_W-1:0]   fitness,
	output logic [rfa_pkg::ECNT_W-1:0]  element_count
);

	rfa_pkg::rfa_q_status_t q_status;
	rfa_pkg::rfa_entry_t    push_entry;
	rfa_pkg::rfa_entry_t    head;
	logic                   push;
	logic                   pop;

	rfa_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.coordinate      (coordinate),
		.last_coordinate (last_coordinate),
		.q_status        (q_status),
		.push            (push),
		.push_entry      (push_entry)
	);

	rfa_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	rfa_back #(
		.MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fitness       (fitness),
		.element_count (element_count)
	);

endmodule

FILE: src/rfa_front.sv
// Front end: takes coordinates and turns each into its per-element Rastrigin term.
module rfa_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    coordinate,
	input  logic                  last_coordinate,
	input  rfa_pkg::rfa_q_status_t q_status,
	output logic                  push,
	output rfa_pkg::rfa_entry_t   push_entry
);

	logic signed [31:0]        prod;
	logic [20:0]               sq;
	logic [1:0]                quad;
	logic [7:0]                frac;
	logic [8:0]                mirror;
	logic [7:0]                rom_idx;
	logic                      rom_zero;
	logic [rfa_pkg::COS_W-1:0] mag;
	logic                      neg;
	logic [12:0]               one_minus_cos;
	logic [16:0]               times_ten;
	logic [15:0]               cterm;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	// x*x is Q.20, rounded back to Q.10
	assign prod = coordinate * coordinate;
	assign sq   = 21'((prod[30:0] + 31'd512) >> 10);

	// Phase is the fractional part of x: 1024 steps per period
	assign quad   = coordinate[9:8];
	assign frac   = coordinate[7:0];
	assign mirror = 9'd256 - {1'b0, frac};

	always_comb begin
		rom_idx  = frac;
		rom_zero = 1'b0;
		neg      = 1'b0;
		case (quad)
			2'd0: begin
				rom_idx = frac;
			end
			2'd1: begin
				rom_idx  = mirror[7:0];
				rom_zero = mirror[8];
				neg      = 1'b1;
			end
			2'd2: begin
				rom_idx = frac;
				neg     = 1'b1;
			end
			2'd3: begin
				rom_idx  = mirror[7:0];
				rom_zero = mirror[8];
			end
			default: begin
				rom_idx = frac;
			end
		endcase
	end

	assign mag = rom_zero ? '0 : rfa_pkg::COS_ROM[rom_idx*rfa_pkg::COS_W +: rfa_pkg::COS_W];

	// 2048 - c, with c signed by quadrant
	assign one_minus_cos = neg ? (13'd2048 + 13'(mag)) : (13'd2048 - 13'(mag));
	assign times_ten     = {1'b0, one_minus_cos, 3'b000} + {3'b000, one_minus_cos, 1'b0};
	assign cterm         = 16'((times_ten + 17'd1) >> 1);

	assign push_entry.term = sq + 21'(cterm);
	assign push_entry.last = last_coordinate;

endmodule

FILE: src/rfa_fifo.sv
// Short queue of per-element terms between the front and back ends.
`include "rastrigin_fitness_accumulator_defines.svh"

module rfa_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rfa_pkg::rfa_entry_t    push_entry,
	input  logic                   pop,
	output rfa_pkg::rfa_entry_t    head,
	output rfa_pkg::rfa_q_status_t status
);

	rfa_pkg::rfa_entry_t          mem_q [rfa_pkg::Q_DEPTH];
	logic [rfa_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [rfa_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [rfa_pkg::Q_PTR_W:0]    fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (fill_q == (rfa_pkg::Q_PTR_W+1)'(rfa_pkg::Q_DEPTH));
	assign status.empty = (fill_q == '0);

	`RFA_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !status.full)
	`RFA_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !status.empty)
	`RFA_ASSERT_NEXT(a_fill_tracks, clk, arst_n, push && !pop && !status.full, !status.empty)

endmodule

FILE: src/rfa_back.sv
// Back end: saturating accumulation, element count and the result register.
`include "rastrigin_fitness_accumulator_defines.svh"

module rfa_back #(
	parameter int MAX_VECTOR_LENGTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rfa_pkg::rfa_entry_t         head,
	input  rfa_pkg::rfa_q_status_t      q_status,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rfa_pkg::FIT_W-1:0]   fitness,
	output logic [rfa_pkg::ECNT_W-1:0]  element_count
);

	localparam int CNT_W = $clog2(MAX_VECTOR_LENGTH + 1);

	logic [rfa_pkg::SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic                               out_valid_q;
	logic [rfa_pkg::FIT_W-1:0]          fitness_q;
	logic [rfa_pkg::ECNT_W-1:0]         ecnt_q;
	logic [rfa_pkg::SUM_W:0]            total;
	logic [rfa_pkg::SUM_W-1:0]          sum_next;
	logic [CNT_W-1:0]                   cnt_next;
	logic [CNT_W+rfa_pkg::ECNT_W-1:0]   cnt_ext;

	// A last entry needs the result slot free (or freeing this cycle)
	assign pop = !q_status.empty && (!head.last || !out_valid_q || out_ready);

	assign total    = {1'b0, sum_q} + (rfa_pkg::SUM_W+1)'(head.term);
	assign sum_next = total[rfa_pkg::SUM_W] ? '1 : total[rfa_pkg::SUM_W-1:0];
	assign cnt_next = (cnt_q < CNT_W'(MAX_VECTOR_LENGTH)) ? cnt_q + 1'b1 : cnt_q;
	assign cnt_ext  = {{rfa_pkg::ECNT_W{1'b0}}, cnt_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.last) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			fitness_q <= sum_next;
			ecnt_q    <= cnt_ext[rfa_pkg::ECNT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign fitness       = fitness_q;
	assign element_count = ecnt_q;

	`RFA_ASSERT_NEXT(a_last_loads_result, clk, arst_n, pop && head.last, out_valid_q)
	`RFA_ASSERT_NOW(a_cnt_bounded, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_VECTOR_LENGTH))
	`RFA_ASSERT_NOW(a_no_overwrite, clk, arst_n, pop && head.last && out_valid_q, out_ready)

endmodule
